/* rtl/rolling_key_xor_stream_cipher_macros.svh */
// Assertion macros for the rolling-key XOR stream cipher.
// Uses the clock and reset names of the including module; no other dependency.
`ifndef ROLLING_KEY_XOR_STREAM_CIPHER_MACROS_SVH
`define ROLLING_KEY_XOR_STREAM_CIPHER_MACROS_SVH

// same-cycle implication
`define RKX_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rkx assertion failed");

// next-cycle implication
`define RKX_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rkx assertion failed");

`endif

/* rtl/rkx_pkg.sv */
// Shared types and constants for the rolling-key XOR stream cipher.
// No dependencies.
package rkx_pkg;

   localparam int KEY_DEPTH  = 1024;
   localparam int KEY_AW     = $clog2(KEY_DEPTH);
   localparam int POS_W      = 10;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 11;
   localparam int OPQ_DEPTH  = 4;
   localparam int RSPQ_DEPTH = 4;

   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_CIPHER = 1'b1
   } func_type;

   typedef struct packed {
      func_type            func;
      logic                wr_en;
      logic [KEY_AW-1:0]   addr;
      logic [BYTE_W-1:0]   data;
   } op_type;

endpackage

/* rtl/rkx_front.sv */
// Front end: request acceptance, key length register and running key offset.
// Depends on rkx_pkg.
module rkx_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      req_func,
   input  logic [rkx_pkg::POS_W-1:0] req_key_position,
   input  logic [rkx_pkg::BYTE_W-1:0] req_byte_value,
   input  logic                      csr_wr_en,
   input  logic [rkx_pkg::LEN_W-1:0] csr_wr_data,
   input  logic                      opq_full,
   output logic                      opq_push,
   output rkx_pkg::op_type           opq_op
);
   import rkx_pkg::*;

   logic [LEN_W-1:0]  key_length_ff, key_length_in;
   logic [KEY_AW-1:0] key_offset_ff, key_offset_in;
   logic [LEN_W-1:0]  len_eff;
   logic [KEY_AW:0]   offset_inc;
   logic              accept;
   func_type          func;

   assign accept   = push && !opq_full;
   assign opq_push = accept;
   assign func     = func_type'(req_func);

   always_comb begin
      if (key_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(key_length_ff) > KEY_DEPTH) begin
         len_eff = LEN_W'(KEY_DEPTH);
      end else begin
         len_eff = key_length_ff;
      end
   end

   assign offset_inc    = {1'b0, key_offset_ff} + (KEY_AW+1)'(1);
   assign key_length_in = csr_wr_en ? csr_wr_data : key_length_ff;

   always_comb begin
      key_offset_in = key_offset_ff;
      opq_op.func   = func;
      opq_op.data   = req_byte_value;
      unique case (func)
         FUNC_LOAD: begin
            opq_op.wr_en = 32'(req_key_position) < KEY_DEPTH;
            opq_op.addr  = KEY_AW'(req_key_position);
            if (accept) begin
               key_offset_in = '0;
            end
         end
         FUNC_CIPHER: begin
            opq_op.wr_en = 1'b1;
            opq_op.addr  = key_offset_ff;
            if (accept) begin
               key_offset_in = (32'(offset_inc) >= 32'(len_eff)) ? '0
                                                                   : KEY_AW'(offset_inc);
            end
         end
         default: begin
            opq_op.wr_en = 1'b0;
            opq_op.addr  = key_offset_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= LEN_W'(1);
         key_offset_ff <= '0;
      end else begin
         key_length_ff <= key_length_in;
         key_offset_ff <= key_offset_in;
      end
   end

endmodule

/* rtl/rkx_op_queue.sv */
// Short request queue between front end and back end.
// Depends on rkx_pkg.
module rkx_op_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_push,
   input  rkx_pkg::op_type wr_op,
   output logic            full,
   input  logic            rd_pop,
   output logic            rd_empty,
   output rkx_pkg::op_type rd_op
);
   import rkx_pkg::*;

   localparam int PTR_W = $clog2(OPQ_DEPTH);
   localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

   op_type             slot_ff [OPQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = count_ff == CNT_W'(OPQ_DEPTH);
   assign rd_empty = count_ff == '0;
   assign rd_op    = slot_ff[rd_ptr_ff];
   assign do_push  = wr_push && !full;
   assign do_pop   = rd_pop && !rd_empty;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(32'(wr_ptr_ff) + 1 == OPQ_DEPTH ? 0 : 32'(wr_ptr_ff) + 1)
                          : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(32'(rd_ptr_ff) + 1 == OPQ_DEPTH ? 0 : 32'(rd_ptr_ff) + 1)
                          : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/rkx_back.sv */
// Back end: key store read-modify-write with forwarding, and the response queue.
// Depends on rkx_pkg and rolling_key_xor_stream_cipher_macros.svh.
`include "rolling_key_xor_stream_cipher_macros.svh"

module rkx_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       opq_empty,
   input  rkx_pkg::op_type            opq_op,
   output logic                       opq_pop,
   input  logic                       pop,
   output logic                       empty,
   output logic [rkx_pkg::BYTE_W-1:0] rsp_cipher_byte
);
   import rkx_pkg::*;

   localparam int PTR_W = $clog2(RSPQ_DEPTH);
   localparam int CNT_W = $clog2(RSPQ_DEPTH + 1);

   // key store, contents undefined until written
   logic [BYTE_W-1:0]  key_mem [KEY_DEPTH];

   op_type             b_op_ff;
   logic               b_valid_ff;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               fwd_hit_ff;
   logic [BYTE_W-1:0]  fwd_data_ff;

   logic [BYTE_W-1:0]  key_cur, wdata;
   logic [KEY_AW:0]    odd_step;
   logic               b_is_cipher, b_done, b_go, mem_we;

   logic [BYTE_W-1:0]  rsp_slot_ff [RSPQ_DEPTH];
   logic [PTR_W-1:0]   rsp_wr_ptr_ff, rsp_rd_ptr_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic               rsp_full, rsp_push, rsp_pop;

   assign key_cur     = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign b_is_cipher = b_valid_ff && (b_op_ff.func == FUNC_CIPHER);
   assign rsp_full    = rsp_count_ff == CNT_W'(RSPQ_DEPTH);
   assign b_done      = b_valid_ff && !(b_is_cipher && rsp_full);
   assign b_go        = !b_valid_ff || b_done;
   assign opq_pop     = b_go && !opq_empty;
   assign mem_we      = b_done && b_op_ff.wr_en;
   assign odd_step    = {b_op_ff.addr, 1'b1};
   assign wdata       = b_is_cipher ? key_cur + BYTE_W'(odd_step) : b_op_ff.data;
   assign rsp_push    = b_done && b_is_cipher;
   assign rsp_pop     = pop && !empty;
   assign empty       = rsp_count_ff == '0;
   assign rsp_cipher_byte = rsp_slot_ff[rsp_rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[b_op_ff.addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (opq_pop) begin
         rd_data_ff <= key_mem[opq_op.addr];
         b_op_ff    <= opq_op;
      end
      if (b_go) begin
         fwd_data_ff <= wdata;
      end
      if (rsp_push) begin
         rsp_slot_ff[rsp_wr_ptr_ff] <= b_op_ff.data ^ key_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         rsp_wr_ptr_ff <= '0;
         rsp_rd_ptr_ff <= '0;
         rsp_count_ff  <= '0;
      end else begin
         if (b_go) begin
            b_valid_ff <= opq_pop;
            fwd_hit_ff <= mem_we && opq_pop && (b_op_ff.addr == opq_op.addr);
         end
         if (rsp_push) begin
            rsp_wr_ptr_ff <= PTR_W'(32'(rsp_wr_ptr_ff) + 1 == RSPQ_DEPTH ? 0
                                    : 32'(rsp_wr_ptr_ff) + 1);
         end
         if (rsp_pop) begin
            rsp_rd_ptr_ff <= PTR_W'(32'(rsp_rd_ptr_ff) + 1 == RSPQ_DEPTH ? 0
                                    : 32'(rsp_rd_ptr_ff) + 1);
         end
         rsp_count_ff <= rsp_count_ff + CNT_W'(rsp_push) - CNT_W'(rsp_pop);
      end
   end

   `RKX_ASSERT_IMPL(a_rsp_no_overflow, rsp_push, rsp_count_ff != CNT_W'(RSPQ_DEPTH))
   `RKX_ASSERT_IMPL(a_fwd_needs_op, fwd_hit_ff, b_valid_ff)
   `RKX_ASSERT_NEXT(a_stall_holds_op, b_valid_ff && !b_go, b_valid_ff && $stable(b_op_ff))

endmodule

/* rtl/rolling_key_xor_stream_cipher.sv */
// Top level of the rolling-key XOR stream cipher.
// Depends on rkx_pkg, rkx_front, rkx_op_queue and rkx_back.
//
// Request side: push with req_func, req_key_position and req_byte_value;
// a request is taken at a clock edge with push high and full low.
// req_func = 0 loads one key byte and restarts the key offset at zero;
// req_func = 1 ciphers a byte and yields one response.
// Response side: rsp_cipher_byte is valid while empty is low and is taken
// at an edge with pop high. csr_wr_en / csr_wr_data set the key length;
// write only while no request is in flight.
// Path: a request is held in the request queue, then in the back-end
// stage while the key store is read, then in the response queue for pop.
// Throughput: one request per cycle while the response queue has room, set
// by the single read-modify-write of the key store per byte; back-to-back
// bytes on the same key entry are forwarded so no bubble is needed.
// Reset: queues empty, key offset zero, key length one. The key store is
// not cleared and must be loaded before use.
// If pop is held low the response queue fills, the back end stalls and the
// request queue fills behind it; full then rises and no request is lost.
module rolling_key_xor_stream_cipher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_func,
   input  logic [rkx_pkg::POS_W-1:0]   req_key_position,
   input  logic [rkx_pkg::BYTE_W-1:0]  req_byte_value,
   output logic                        empty,
   input  logic                        pop,
   output logic [rkx_pkg::BYTE_W-1:0]  rsp_cipher_byte,
   input  logic                        csr_wr_en,
   input  logic [rkx_pkg::LEN_W-1:0]   csr_wr_data
);
   import rkx_pkg::*;

   logic   opq_push, opq_full, opq_pop, opq_empty;
   op_type front_op, head_op;

   assign full = opq_full;

   rkx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_func         (req_func),
      .req_key_position (req_key_position),
      .req_byte_value   (req_byte_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .opq_full         (opq_full),
      .opq_push         (opq_push),
      .opq_op           (front_op)
   );

   rkx_op_queue u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (opq_push),
      .wr_op    (front_op),
      .full     (opq_full),
      .rd_pop   (opq_pop),
      .rd_empty (opq_empty),
      .rd_op    (head_op)
   );

   rkx_back u_back (
      .clock           (clock),
      .reset           (reset),
      .opq_empty       (opq_empty),
      .opq_op          (head_op),
      .opq_pop         (opq_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_cipher_byte (rsp_cipher_byte)
   );

endmodule
